>>> rtl/stli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_pkg
// Shared types and codes for the sorted-table linear interpolator.
// ----------------------------------------------------------------------------
package stli_pkg;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_TOOFEW = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] y_result;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_QUERY,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage

>>> rtl/stli_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_front
// Accepts input beats, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module stli_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stli_pkg::t_in_item  i_in_data,
    output stli_pkg::t_cmd_q    o_cmd,
    input  logic                i_pop
);

    stli_pkg::t_cmd r_ent [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_num;
    stli_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.x = i_in_data.x_value;
        w_cmd.y = i_in_data.y_value;
        case (i_in_data.mode)
            stli_pkg::MODE_CLEAR:  w_cmd.op = stli_pkg::OP_CLEAR;
            stli_pkg::MODE_INSERT: w_cmd.op = stli_pkg::OP_INSERT;
            stli_pkg::MODE_QUERY:  w_cmd.op = stli_pkg::OP_QUERY;
            default:               w_cmd.op = stli_pkg::OP_NOP;
        endcase
    end

    assign o_in_stall  = (r_num == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_pop && (r_num != 2'd0);
    assign o_cmd.valid = (r_num != 2'd0);
    assign o_cmd.cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_num <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_num <= r_num + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_cmd;
        end
    end

endmodule

>>> rtl/stli_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_back
// Knot memory, insertion shifter, binary search, serial multiply and divide,
// and the output register.
// ----------------------------------------------------------------------------
module stli_back #(
    parameter int TABLE_POINTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stli_pkg::t_cmd_q    i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stli_pkg::t_out_item o_out_data
);

    localparam int AW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam int CW = $clog2(TABLE_POINTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_POINTS);

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_INS_CMP, S_INS_PUT, S_Q_LO, S_Q_HI, S_BS, S_BS_CMP,
        S_SEG0, S_SEG1, S_MUL0, S_MUL1, S_DIV, S_FIN, S_EMIT
    } t_state;

    logic signed [31:0] mem_x [TABLE_POINTS];
    logic signed [31:0] mem_y [TABLE_POINTS];

    t_state             r_state;
    t_state             r_ret;
    logic [AW-1:0]      r_ra;
    logic signed [31:0] r_rd_x;
    logic signed [31:0] r_rd_y;
    logic               r_we;
    logic [AW-1:0]      r_wa;
    logic signed [31:0] r_wx;
    logic signed [31:0] r_wy;
    logic signed [31:0] r_xv;
    logic signed [31:0] r_yv;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic signed [31:0] r_x0;
    logic signed [31:0] r_y0;
    logic [32:0]        r_dx;
    logic [32:0]        r_ox;
    logic [32:0]        r_dy;
    logic               r_neg;
    logic [65:0]        r_prod;
    logic [32:0]        r_rem;
    logic [65:0]        r_quo;
    logic [6:0]         r_bit;
    logic signed [31:0] r_res;
    logic [1:0]         r_st;
    logic               r_ovalid;
    stli_pkg::t_out_item r_odata;

    logic [16:0]        w_mop;
    logic [49:0]        w_pp;
    logic [33:0]        w_rr;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_ox;
    logic signed [32:0] w_dy;
    logic [33:0]        w_qs;
    logic signed [34:0] w_sum;
    logic [CW-1:0]      w_mid;
    logic [CW-1:0]      w_lo;
    logic               w_out_free;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem_x[r_wa] <= r_wx;
            mem_y[r_wa] <= r_wy;
        end
        r_rd_x <= mem_x[r_ra];
        r_rd_y <= mem_y[r_ra];
    end

    always_comb begin
        w_mop = (r_state == S_MUL0) ? r_dy[16:0] : {1'b0, r_dy[32:17]};
        w_pp  = 50'(r_ox) * 50'(w_mop);
        w_rr  = {r_rem, r_prod[65]};
        w_dx  = 33'(signed'({r_rd_x[31], r_rd_x})) - 33'(signed'({r_x0[31], r_x0}));
        w_ox  = 33'(signed'({r_xv[31], r_xv})) - 33'(signed'({r_x0[31], r_x0}));
        w_dy  = 33'(signed'({r_rd_y[31], r_rd_y})) - 33'(signed'({r_y0[31], r_y0}));
        w_qs  = (|r_quo[65:33]) ? 34'h2_0000_0000 : {1'b0, r_quo[32:0]};
        w_sum = r_neg ? ({{3{r_y0[31]}}, r_y0} - signed'({1'b0, w_qs}))
                      : ({{3{r_y0[31]}}, r_y0} + signed'({1'b0, w_qs}));
        w_mid = CW'((({1'b0, r_hi}) + ({1'b0, r_lo})) >> 1);
        w_lo  = ((r_lo + CW'(1)) >= r_cnt) ? (r_cnt - CW'(2)) : r_lo;
    end

    assign w_out_free  = !r_ovalid || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && i_cmd.valid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_cnt    <= '0;
            r_we     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_we <= (r_state == S_INS_PUT) || ((r_state == S_INS_CMP) && (r_rd_x > r_xv));
            if ((r_state == S_EMIT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_xv  <= i_cmd.cmd.x;
                        r_yv  <= i_cmd.cmd.y;
                        r_res <= '0;
                        case (i_cmd.cmd.op)
                            stli_pkg::OP_CLEAR: begin
                                r_cnt   <= '0;
                                r_st    <= stli_pkg::ST_OK;
                                r_state <= S_EMIT;
                            end
                            stli_pkg::OP_INSERT: begin
                                r_i <= r_cnt;
                                if (r_cnt == FULL_CNT) begin
                                    r_st    <= stli_pkg::ST_FULL;
                                    r_state <= S_EMIT;
                                end else if (r_cnt == '0) begin
                                    r_st    <= stli_pkg::ST_OK;
                                    r_state <= S_INS_PUT;
                                end else begin
                                    r_st    <= stli_pkg::ST_OK;
                                    r_ra    <= AW'(r_cnt - CW'(1));
                                    r_ret   <= S_INS_CMP;
                                    r_state <= S_WAIT;
                                end
                            end
                            stli_pkg::OP_QUERY: begin
                                if (r_cnt < CW'(2)) begin
                                    r_st    <= stli_pkg::ST_TOOFEW;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_st    <= stli_pkg::ST_OK;
                                    r_ra    <= '0;
                                    r_ret   <= S_Q_LO;
                                    r_state <= S_WAIT;
                                end
                            end
                            default: begin
                                r_st    <= stli_pkg::ST_OK;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_WAIT: begin
                    r_state <= r_ret;
                end
                S_INS_CMP: begin
                    if (r_rd_x > r_xv) begin
                        r_wa <= r_i[AW-1:0];
                        r_wx <= r_rd_x;
                        r_wy <= r_rd_y;
                        r_i  <= r_i - CW'(1);
                        if (r_i == CW'(1)) begin
                            r_state <= S_INS_PUT;
                        end else begin
                            r_ra    <= AW'(r_i - CW'(2));
                            r_ret   <= S_INS_CMP;
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    r_wa    <= r_i[AW-1:0];
                    r_wx    <= r_xv;
                    r_wy    <= r_yv;
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_EMIT;
                end
                S_Q_LO: begin
                    if (r_xv < r_rd_x) begin
                        r_st    <= stli_pkg::ST_RANGE;
                        r_state <= S_EMIT;
                    end else begin
                        r_ra    <= AW'(r_cnt - CW'(1));
                        r_ret   <= S_Q_HI;
                        r_state <= S_WAIT;
                    end
                end
                S_Q_HI: begin
                    if (r_xv > r_rd_x) begin
                        r_st    <= stli_pkg::ST_RANGE;
                        r_state <= S_EMIT;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= r_cnt;
                        r_state <= S_BS;
                    end
                end
                S_BS: begin
                    if ((r_hi - r_lo) > CW'(1)) begin
                        r_i     <= w_mid;
                        r_ra    <= w_mid[AW-1:0];
                        r_ret   <= S_BS_CMP;
                        r_state <= S_WAIT;
                    end else begin
                        r_i     <= w_lo + CW'(1);
                        r_ra    <= w_lo[AW-1:0];
                        r_ret   <= S_SEG0;
                        r_state <= S_WAIT;
                    end
                end
                S_BS_CMP: begin
                    if (r_xv > r_rd_x) begin
                        r_lo <= r_i;
                    end else begin
                        r_hi <= r_i;
                    end
                    r_state <= S_BS;
                end
                S_SEG0: begin
                    r_x0    <= r_rd_x;
                    r_y0    <= r_rd_y;
                    r_ra    <= r_i[AW-1:0];
                    r_ret   <= S_SEG1;
                    r_state <= S_WAIT;
                end
                S_SEG1: begin
                    if (w_dx[32] || (w_dx == '0)) begin
                        r_st    <= stli_pkg::ST_TOOFEW;
                        r_state <= S_EMIT;
                    end else begin
                        r_dx    <= w_dx;
                        r_ox    <= w_ox[32] ? 33'(-w_ox) : w_ox;
                        r_dy    <= w_dy[32] ? 33'(-w_dy) : w_dy;
                        r_neg   <= w_ox[32] != w_dy[32];
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_prod  <= 66'(w_pp);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod  <= r_prod + (66'(w_pp) << 17);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_bit   <= 7'd65;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rr >= {1'b0, r_dx}) begin
                        r_rem <= 33'(w_rr - {1'b0, r_dx});
                        r_quo <= {r_quo[64:0], 1'b1};
                    end else begin
                        r_rem <= w_rr[32:0];
                        r_quo <= {r_quo[64:0], 1'b0};
                    end
                    r_prod <= {r_prod[64:0], 1'b0};
                    r_bit  <= r_bit - 7'd1;
                    if (r_bit == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_sum > 35'sd2147483647) begin
                        r_res <= 32'sh7fff_ffff;
                    end else if (w_sum < -35'sd2147483648) begin
                        r_res <= 32'sh8000_0000;
                    end else begin
                        r_res <= w_sum[31:0];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_odata.y_result <= r_res;
                        r_odata.status   <= r_st;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT) else $error("knot count beyond table size");
    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> (CW'(r_wa) <= r_cnt)) else $error("write past fill level");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < {1'b0, r_dx}))
        else $error("divider remainder out of range");
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_EMIT))
        else $error("result loaded outside emit");
`endif

endmodule

>>> rtl/sorted_table_linear_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_core
// Sorted knot table with insert, clear and piecewise linear query.
// ----------------------------------------------------------------------------
// Each beat is handled one at a time by the back end while the front queue
// (two entries) keeps taking input until it is full. Every knot memory read
// goes through a registered address and a registered read before the data is
// used. A clear, an unused mode, a full-table insert or a query on fewer than
// two knots goes straight from idle to emit; an insert compares the knots from
// the top down and shifts up each one above the new one, then writes it. A
// query goes through the reads and compares of a binary search, a multiply on
// the low and high halves of the rise, 66 restoring divide steps, saturation
// and emit; the divider produces one quotient bit per cycle. No clearing pass is needed after reset.
module sorted_table_linear_interpolator_core #(
    parameter int TABLE_POINTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stli_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stli_pkg::t_out_item o_out_data
);

    stli_pkg::t_cmd_q w_cmd;
    logic             w_pop;

    stli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_cmd      (w_cmd),
        .i_pop      (w_pop)
    );

    stli_back #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> dv/tb_sorted_table_linear_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_linear_interpolator_core
// Self-checking bench for the sorted-table interpolator: directed clears,
// inserts and queries on end points, duplicates and a full table, then
// random knot tables queried in and out of range, with random input gaps
// and output stalls. Every result beat is checked against a local model.
// ----------------------------------------------------------------------------
module tb_sorted_table_linear_interpolator_core;

    localparam int NPTS = 256;
    localparam int WDOG_LIMIT = 40000;
    localparam logic [1:0] MODE_NOP = 2'(stli_pkg::OP_NOP);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    stli_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    stli_pkg::t_out_item o_out_data;

    logic signed [31:0]  knot_x [NPTS];
    logic signed [31:0]  knot_y [NPTS];
    int                  n_knots = 0;
    stli_pkg::t_out_item pending_results [$];
    int                  err_count = 0;
    int                  idle_cycles = 0;
    int                  stall_pct = 30;
    int                  stall_run = 0;

    sorted_table_linear_interpolator_core #(.TABLE_POINTS(NPTS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic stli_pkg::t_out_item interpolate_step(stli_pkg::t_in_item it);
        stli_pkg::t_out_item r;
        int                  lo, hi, mid, p;
        longint              x0, x1, y0, y1, dx, dy, ox, res;
        logic [127:0]        q;
        logic [63:0]         oxm, dym;
        bit                  neg;
        r = '0;
        case (it.mode)
            stli_pkg::MODE_CLEAR: n_knots = 0;
            stli_pkg::MODE_INSERT: begin
                if (n_knots >= NPTS) begin
                    r.status = stli_pkg::ST_FULL;
                end else begin
                    p = n_knots;
                    while (p > 0 && knot_x[p-1] > it.x_value) begin
                        knot_x[p] = knot_x[p-1];
                        knot_y[p] = knot_y[p-1];
                        p--;
                    end
                    knot_x[p] = it.x_value;
                    knot_y[p] = it.y_value;
                    n_knots++;
                end
            end
            stli_pkg::MODE_QUERY: begin
                if (n_knots < 2) begin
                    r.status = stli_pkg::ST_TOOFEW;
                end else if (it.x_value < knot_x[0] || it.x_value > knot_x[n_knots-1]) begin
                    r.status = stli_pkg::ST_RANGE;
                end else begin
                    lo = 0;
                    hi = n_knots;
                    while (hi - lo > 1) begin
                        mid = (hi + lo) >> 1;
                        if (it.x_value > knot_x[mid]) lo = mid;
                        else hi = mid;
                    end
                    if (lo + 1 >= n_knots) lo = n_knots - 2;
                    x0 = knot_x[lo];
                    x1 = knot_x[lo+1];
                    y0 = knot_y[lo];
                    y1 = knot_y[lo+1];
                    dx = x1 - x0;
                    if (dx <= 0) begin
                        r.status = stli_pkg::ST_TOOFEW;
                    end else begin
                        ox = longint'(it.x_value) - x0;
                        dy = y1 - y0;
                        neg = (dy < 0) != (ox < 0);
                        oxm = (ox < 0) ? -ox : ox;
                        dym = (dy < 0) ? -dy : dy;
                        q = (128'(oxm) * 128'(dym)) / 128'(dx);
                        if (q > (128'd1 << 40)) q = 128'd1 << 40;
                        res = neg ? y0 - longint'(q[63:0]) : y0 + longint'(q[63:0]);
                        if (res > 64'sd2147483647) res = 64'sd2147483647;
                        if (res < -64'sd2147483648) res = -64'sd2147483648;
                        r.y_result = res[31:0];
                        r.status = stli_pkg::ST_OK;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        stli_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", o_out_data.y_result, 32'h0);
            end else begin
                e = pending_results.pop_front();
                if (o_out_data.y_result !== e.y_result)
                    report_mismatch("y_result", o_out_data.y_result, e.y_result);
                if (o_out_data.status !== e.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(e.status));
            end
        end
    end

    // output stall, with occasional long runs and stall-free stretches
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run   <= stall_run - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(199) == 0) begin
            stall_run   <= $urandom_range(60, 20);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(99) < stall_pct;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] mode, logic signed [31:0] x, logic signed [31:0] y);
        int                  gap;
        stli_pkg::t_in_item  it;
        stli_pkg::t_out_item exp_item;
        it.mode = mode;
        it.x_value = x;
        it.y_value = y;
        gap = ($urandom_range(9) < 6) ? 0 :
              ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        exp_item = interpolate_step(it);
        pending_results = {pending_results, exp_item};
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(200))) - 100;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic test_empty_and_few();
        send_beat(stli_pkg::MODE_QUERY, 0, $urandom);
        send_beat(stli_pkg::MODE_INSERT, 32'sh00010000, 32'sh00020000);
        send_beat(stli_pkg::MODE_QUERY, 32'sh00010000, 0);
        send_beat(MODE_NOP, $urandom, $urandom);
        send_beat(stli_pkg::MODE_QUERY, 32'sh00010000, 0);
    endtask

    task automatic test_extremes();
        send_beat(stli_pkg::MODE_CLEAR, $urandom, $urandom);
        send_beat(stli_pkg::MODE_INSERT, 32'sh7fffffff, 32'sh80000000);
        send_beat(stli_pkg::MODE_INSERT, 32'sh80000000, 32'sh7fffffff);
        send_beat(stli_pkg::MODE_QUERY, 32'sh80000000, 0);
        send_beat(stli_pkg::MODE_QUERY, 32'sh7fffffff, 0);
        send_beat(stli_pkg::MODE_QUERY, 0, 32'shffffffff);
        send_beat(stli_pkg::MODE_QUERY, 32'sh12345678, 0);
        send_beat(stli_pkg::MODE_INSERT, 0, 32'sh00030000);
        send_beat(stli_pkg::MODE_QUERY, -32'sh00000001, 0);
        send_beat(stli_pkg::MODE_QUERY, 32'sh40000000, 0);
    endtask

    task automatic test_duplicates_and_range();
        send_beat(stli_pkg::MODE_CLEAR, 0, 0);
        send_beat(stli_pkg::MODE_INSERT, 100, 5);
        send_beat(stli_pkg::MODE_INSERT, 100, 9);
        send_beat(stli_pkg::MODE_INSERT, 200, -7);
        send_beat(stli_pkg::MODE_QUERY, 99, 0);
        send_beat(stli_pkg::MODE_QUERY, 201, 0);
        send_beat(stli_pkg::MODE_QUERY, 100, 0);
        send_beat(stli_pkg::MODE_QUERY, 150, 0);
        send_beat(stli_pkg::MODE_QUERY, 200, 0);
    endtask

    task automatic test_full_table();
        int i;
        send_beat(stli_pkg::MODE_CLEAR, 0, 0);
        for (i = 0; i < NPTS; i++)
            send_beat(stli_pkg::MODE_INSERT, i * 1000, $urandom);
        send_beat(stli_pkg::MODE_INSERT, 500, $urandom);
        send_beat(stli_pkg::MODE_QUERY, 0, 0);
        send_beat(stli_pkg::MODE_QUERY, 123456, 0);
        send_beat(stli_pkg::MODE_QUERY, (NPTS - 1) * 1000, 0);
        send_beat(stli_pkg::MODE_CLEAR, 0, 0);
        for (i = 0; i < NPTS; i++)
            send_beat(stli_pkg::MODE_INSERT, -i * 7, $urandom);
        send_beat(stli_pkg::MODE_QUERY, -900, 0);
        send_beat(stli_pkg::MODE_INSERT, 0, 0);
    endtask

    task automatic test_random_tables(int n_items);
        int sent, npts, nq, i;
        longint lo_x, hi_x, span;
        logic signed [31:0] qx;
        sent = 0;
        while (sent < n_items) begin
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(70);
            send_beat(stli_pkg::MODE_CLEAR, $urandom, $urandom);
            npts = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(12);
            for (i = 0; i < npts; i++) begin
                if ($urandom_range(7) == 0 && n_knots > 0)
                    send_beat(stli_pkg::MODE_INSERT, knot_x[$urandom_range(n_knots - 1)],
                              rand_word());
                else
                    send_beat(stli_pkg::MODE_INSERT, rand_word(), rand_word());
            end
            nq = $urandom_range(25, 5);
            for (i = 0; i < nq; i++) begin
                if (n_knots > 0 && $urandom_range(9) < 7) begin
                    lo_x = knot_x[0];
                    hi_x = knot_x[n_knots - 1];
                    span = hi_x - lo_x + 1;
                    qx = (span > 0) ? 32'(lo_x + longint'({$urandom, $urandom} >> 1) % span)
                                    : 32'(lo_x);
                    if ($urandom_range(5) == 0) qx = knot_x[$urandom_range(n_knots - 1)];
                    send_beat(stli_pkg::MODE_QUERY, qx, $urandom);
                end else if ($urandom_range(4) == 0) begin
                    send_beat(MODE_NOP, $urandom, $urandom);
                end else begin
                    send_beat(stli_pkg::MODE_QUERY, rand_word(), $urandom);
                end
            end
            sent += 1 + npts + nq;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_few();
        test_extremes();
        test_duplicates_and_range();
        test_full_table();
        test_random_tables(1150);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/stli_pkg.sv
rtl/stli_front.sv
rtl/stli_back.sv
rtl/sorted_table_linear_interpolator_core.sv
dv/tb_sorted_table_linear_interpolator_core.sv
